### sv/opto_compressor_gain_stage_assert.svh
// Assertion helpers for the compressor gain stage.
`ifndef OPTO_COMPRESSOR_GAIN_STAGE_ASSERT_SVH
`define OPTO_COMPRESSOR_GAIN_STAGE_ASSERT_SVH

`ifndef SYNTHESIS
`define OCGS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OCGS_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define OCGS_ASSERT(lbl, prop, msg)
`define OCGS_ASSERT_ANY(lbl, prop, msg)
`endif

`endif

### sv/ocgs_pkg.sv
`default_nettype none

package ocgs_pkg;

  localparam int unsigned SAMPLE_BITS     = 24;
  localparam int unsigned STATE_FRAC_BITS = 24;

  localparam int unsigned COEFF_BITS = 16;
  localparam int unsigned GAIN_BITS  = 17;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 17'd65536;
  localparam logic [GAIN_BITS-1:0] GAIN_FLOOR = 17'd655;

  localparam int unsigned DIV_STEPS    = GAIN_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_AMOUNT     = 2'd0,
    CFG_FAST_COEFF = 2'd1,
    CFG_SLOW_COEFF = 2'd2
  } cfg_idx_e;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_MAG   = 11'b000_0000_0010,
    S_DRV   = 11'b000_0000_0100,
    S_FASTA = 11'b000_0000_1000,
    S_FASTB = 11'b000_0001_0000,
    S_SLOWA = 11'b000_0010_0000,
    S_SLOWB = 11'b000_0100_0000,
    S_DINIT = 11'b000_1000_0000,
    S_DIV   = 11'b001_0000_0000,
    S_GAIN  = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

endpackage

`default_nettype wire

### sv/opto_compressor_gain_stage.sv
// Feed-forward compressor gain stage.
// Input channel: in_valid_i / in_stall_o with sample_in_i, a signed sample
// (full scale 1.0). A transaction completes when valid is high and stall low.
// Output channel: out_valid_o / out_stall_i with sample_out_o (sample times
// gain) and gain_o (linear Q16 gain, 655 .. 65536).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 amount,
// 1 fast pole, 2 slow pole) and cfg_data_i; ready is always high, other
// indexes are dropped. Write only while no sample is in flight.
// Sequencing: a new sample is taken only once the result of the previous one
// has been loaded into the output register. The sequencer uses one shared
// multiplier for six products in turn and a restoring divider that forms
// one of the 17 gain bits per cycle.
// The result sits in an output register, so a stalled receiver does not
// block the next input; the sequencer holds only if a second result is
// ready while the first is still stalled.
// Reset clears the state, the configuration registers, both smoother levels and the output valid.
`default_nettype none

`include "opto_compressor_gain_stage_assert.svh"

module opto_compressor_gain_stage
  import ocgs_pkg::*;
#(
  parameter int unsigned SampleBits    = ocgs_pkg::SAMPLE_BITS,
  parameter int unsigned StateFracBits = ocgs_pkg::STATE_FRAC_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SampleBits-1:0]   sample_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [SampleBits-1:0]        sample_out_o,
  output logic [GAIN_BITS-1:0]                gain_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [CFG_IDX_BITS-1:0]        cfg_index_i,
  input  wire logic [COEFF_BITS-1:0]          cfg_data_i
);

  localparam int unsigned LW = StateFracBits + 4;
  localparam int unsigned MA = (SampleBits > LW) ? SampleBits : LW;
  localparam int unsigned PW = MA + GAIN_BITS;
  localparam int unsigned DW = StateFracBits + 23;
  localparam int unsigned SH = SampleBits + 15 - StateFracBits;

  localparam logic [DW-1:0] NUM_ONE  = {{(DW-1){1'b0}}, 1'b1} << (16 + StateFracBits);
  localparam logic [DW-1:0] DEN_ONE  = {{(DW-1){1'b0}}, 1'b1} << StateFracBits;
  localparam logic [PW:0]   RND_POS  = (PW+1)'(32768);
  localparam logic [PW:0]   RND_NEG  = (PW+1)'(32767);
  localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIV_STEPS - 1);

  state_e state_q, state_d;

  logic [COEFF_BITS-1:0] amount_q, fast_coeff_q, slow_coeff_q;
  logic [LW-1:0]         fast_q, slow_q;
  logic [LW-1:0]         drive_q;
  logic [SampleBits-1:0] mag_q;
  logic                  neg_q;
  logic [PW-1:0]         prod_q, acc_q;
  logic [DW-1:0]         rem_q, dsr_q;
  logic [GAIN_BITS-1:0]  quo_q, gain_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic                  out_valid_q;
  logic signed [SampleBits-1:0] sample_out_q;
  logic [GAIN_BITS-1:0]  gain_out_q;

  logic [MA-1:0]         mul_a;
  logic [GAIN_BITS-1:0]  mul_b;
  logic                  in_take;
  logic                  out_load;
  logic [SampleBits-1:0] mag_in;
  logic [PW+2:0]         drv_full;
  logic [PW:0]           lvl_sum;
  logic [LW-1:0]         lvl_new;
  logic [DW-1:0]         den;
  logic [GAIN_BITS-1:0]  gain_clamp;
  logic [PW:0]           rnd;
  logic [SampleBits-1:0] rnd_mag;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign gain_o       = gain_out_q;

  assign mag_in   = sample_in_i[SampleBits-1] ? SampleBits'(-sample_in_i) : sample_in_i;
  assign drv_full = {prod_q, 3'b000} - {2'b00, prod_q, 1'b0};
  assign lvl_sum  = {1'b0, acc_q} + {1'b0, prod_q};
  assign lvl_new  = lvl_sum[16 +: LW];
  assign den      = DEN_ONE + DW'({slow_q, 2'b00});
  assign gain_clamp = (quo_q < GAIN_FLOOR) ? GAIN_FLOOR : quo_q;
  assign rnd      = {1'b0, prod_q} + (neg_q ? RND_NEG : RND_POS);
  assign rnd_mag  = rnd[16 +: SampleBits];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_MAG: begin
        mul_a = MA'(mag_q);
        mul_b = GAIN_BITS'(amount_q);
      end
      S_DRV: begin
        mul_a = MA'(fast_q);
        mul_b = GAIN_BITS'(fast_coeff_q);
      end
      S_FASTA: begin
        mul_a = MA'(drive_q);
        mul_b = GAIN_ONE - GAIN_BITS'(fast_coeff_q);
      end
      S_FASTB: begin
        mul_a = MA'(slow_q);
        mul_b = GAIN_BITS'(slow_coeff_q);
      end
      S_SLOWA: begin
        mul_a = MA'(fast_q);
        mul_b = GAIN_ONE - GAIN_BITS'(slow_coeff_q);
      end
      S_GAIN: begin
        mul_a = MA'(mag_q);
        mul_b = gain_clamp;
      end
      S_OUT: begin
        mul_a = MA'(mag_q);
        mul_b = gain_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_take) state_d = S_MAG;
      S_MAG:   state_d = S_DRV;
      S_DRV:   state_d = S_FASTA;
      S_FASTA: state_d = S_FASTB;
      S_FASTB: state_d = S_SLOWA;
      S_SLOWA: state_d = S_SLOWB;
      S_SLOWB: state_d = S_DINIT;
      S_DINIT: state_d = S_DIV;
      S_DIV:   if (cnt_q == '0) state_d = S_GAIN;
      S_GAIN:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      amount_q     <= '0;
      fast_coeff_q <= '0;
      slow_coeff_q <= '0;
      fast_q       <= '0;
      slow_q       <= '0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_AMOUNT:     amount_q     <= cfg_data_i;
          CFG_FAST_COEFF: fast_coeff_q <= cfg_data_i;
          CFG_SLOW_COEFF: slow_coeff_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_FASTB) fast_q <= lvl_new;
      if (state_q == S_SLOWB) slow_q <= lvl_new;
      if (state_q == S_DINIT) cnt_q <= DIV_LAST;
      else if (state_q == S_DIV) cnt_q <= cnt_q - 1'b1;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(mul_a * mul_b);
    if (in_take) begin
      mag_q <= mag_in;
      neg_q <= sample_in_i[SampleBits-1];
    end
    if (state_q == S_DRV) drive_q <= LW'(drv_full >> SH);
    if (state_q == S_FASTA || state_q == S_SLOWA) acc_q <= prod_q;
    if (state_q == S_DINIT) begin
      rem_q <= NUM_ONE + (den >> 1);
      dsr_q <= den << 16;
      quo_q <= '0;
    end else if (state_q == S_DIV) begin
      if (rem_q >= dsr_q) begin
        rem_q <= rem_q - dsr_q;
        quo_q <= {quo_q[GAIN_BITS-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[GAIN_BITS-2:0], 1'b0};
      end
      dsr_q <= dsr_q >> 1;
    end
    if (state_q == S_GAIN) gain_q <= gain_clamp;
    if (out_load) begin
      sample_out_q <= neg_q ? -rnd_mag : rnd_mag;
      gain_out_q   <= gain_q;
    end
  end

  `OCGS_ASSERT(a_take_starts_seq, in_take |=> (state_q == S_MAG), "sequence did not start")
  `OCGS_ASSERT(a_div_ends_gain, (state_q == S_DIV && cnt_q == '0) |=> (state_q == S_GAIN), "divider overran")
  `OCGS_ASSERT(a_load_only_free, out_load |-> (!out_valid_q || !out_stall_i), "result overwrote stalled output")
  `OCGS_ASSERT_ANY(a_gain_range, !rst_ni || !out_valid_o || (gain_o >= GAIN_FLOOR && gain_o <= GAIN_ONE), "gain out of range")

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top
  import ocgs_pkg::*;
();

  localparam int unsigned LVL_BITS        = STATE_FRAC_BITS + 4;
  localparam int unsigned DRIVE_SHIFT     = SAMPLE_BITS - 1 + COEFF_BITS - STATE_FRAC_BITS;
  localparam int unsigned CYCLE_LIMIT     = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 48;
  localparam int unsigned N_DIR           = 25;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_NONE = 2'd3;

  localparam logic [SAMPLE_BITS-1:0] SMP_MAX  = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] SMP_MIN  = 24'h800000;
  localparam logic [SAMPLE_BITS-1:0] SMP_ZERO = 24'h000000;
  localparam logic [SAMPLE_BITS-1:0] SMP_ONE  = 24'h000001;
  localparam logic [SAMPLE_BITS-1:0] SMP_NEG1 = 24'hFFFFFF;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [CFG_IDX_BITS-1:0]   idx;
    logic [SAMPLE_BITS-1:0]    value;
    logic                      typed;
    logic [SAMPLE_BITS-1:0]    exp_smp;
    logic [GAIN_BITS-1:0]      exp_gain;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp_out;
    logic [GAIN_BITS-1:0]          gain;
  } gain_result_t;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;
  logic [GAIN_BITS-1:0]          gain_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i = CFG_IDX_NONE;
  logic [COEFF_BITS-1:0]         cfg_data_i  = '0;

  logic [COEFF_BITS-1:0] amount_r    = '0;
  logic [COEFF_BITS-1:0] fast_pole_r = '0;
  logic [COEFF_BITS-1:0] slow_pole_r = '0;
  logic [LVL_BITS-1:0]   fast_lvl    = '0;
  logic [LVL_BITS-1:0]   slow_lvl    = '0;

  gain_result_t pending_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count    = 0;
  bit           calm_mode      = 1'b0;
  bit           hold_off_req   = 1'b0;

  stim_row_t dir_tbl [N_DIR] = '{
    '{ROW_SMP, CFG_IDX_NONE, SMP_ZERO, 1'b1, SMP_ZERO, GAIN_ONE},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MAX,  1'b1, SMP_MAX,  GAIN_ONE},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MIN,  1'b1, SMP_MIN,  GAIN_ONE},
    '{ROW_SMP, CFG_IDX_NONE, SMP_NEG1, 1'b1, SMP_NEG1, GAIN_ONE},
    '{ROW_SMP, CFG_IDX_NONE, SMP_ONE,  1'b1, SMP_ONE,  GAIN_ONE},
    '{ROW_CFG, CFG_IDX_NONE, 24'h00FFFF, 1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MAX,  1'b1, SMP_MAX,  GAIN_ONE},
    '{ROW_CFG, CFG_AMOUNT,     24'h00FFFF, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_FAST_COEFF, 24'h000000, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_SLOW_COEFF, 24'h000000, 1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MIN,  1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MAX,  1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, SMP_ZERO, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_FAST_COEFF, 24'h00FFFF, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_SLOW_COEFF, 24'h00FFFF, 1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MIN,    1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, 24'h555555, 1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, 24'hAAAAAA, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_AMOUNT,   24'h000001, 1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MIN,    1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_AMOUNT,     24'h000000, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_FAST_COEFF, 24'h000000, 1'b0, SMP_ZERO, '0},
    '{ROW_CFG, CFG_SLOW_COEFF, 24'h000000, 1'b0, SMP_ZERO, '0},
    '{ROW_SMP, CFG_IDX_NONE, 24'h003039, 1'b1, 24'h003039, GAIN_ONE},
    '{ROW_SMP, CFG_IDX_NONE, SMP_MIN,    1'b1, SMP_MIN,    GAIN_ONE}
  };

  opto_compressor_gain_stage i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .gain_o       (gain_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [LVL_BITS-1:0] smooth_level(input logic [COEFF_BITS-1:0] pole,
                                                       input logic [LVL_BITS-1:0] lvl,
                                                       input logic [LVL_BITS-1:0] tgt);
    longint unsigned acc;
    acc = (64'(pole) * lvl + ((64'd1 << COEFF_BITS) - pole) * tgt) >> COEFF_BITS;
    return LVL_BITS'(acc);
  endfunction

  // Advance both smoother levels and form the gain from the new slow level.
  function automatic gain_result_t compress_sample(input logic signed [SAMPLE_BITS-1:0] smp);
    longint          sx;
    longint          prod;
    longint unsigned mag;
    longint unsigned drive;
    longint unsigned den;
    longint unsigned g;
    gain_result_t    res;
    sx    = smp;
    mag   = (sx < 0) ? -sx : sx;
    drive = (mag * amount_r * 64'd6) >> DRIVE_SHIFT;
    fast_lvl = smooth_level(fast_pole_r, fast_lvl, LVL_BITS'(drive));
    slow_lvl = smooth_level(slow_pole_r, slow_lvl, fast_lvl);
    den = (64'd1 << STATE_FRAC_BITS) + 64'd4 * slow_lvl;
    g   = ((64'd1 << (COEFF_BITS + STATE_FRAC_BITS)) + (den >> 1)) / den;
    if (g < GAIN_FLOOR) g = GAIN_FLOOR;
    if (g > GAIN_ONE) g = GAIN_ONE;
    prod = sx * longint'(g) + (longint'(1) << (COEFF_BITS - 1));
    res.smp_out = SAMPLE_BITS'(prod >>> COEFF_BITS);
    res.gain    = GAIN_BITS'(g);
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_mode || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [COEFF_BITS-1:0] pick_reg_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 65) return COEFF_BITS'(65535 - $urandom_range(0, 3000));
    return COEFF_BITS'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned     r;
    logic [SAMPLE_BITS-1:0] mag;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      case ($urandom_range(0, 4))
        0: return SMP_MAX;
        1: return SMP_MIN;
        2: return SMP_ZERO;
        3: return SMP_ONE;
        default: return SMP_NEG1;
      endcase
    end
    if (r < 50) return SAMPLE_BITS'($urandom);
    if (r < 75) return SAMPLE_BITS'($urandom_range(0, 4095) - 2048);
    mag = SAMPLE_BITS'($urandom_range(4194304, 8388607));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [COEFF_BITS-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_AMOUNT:     amount_r    = data;
      CFG_FAST_COEFF: fast_pole_r = data;
      CFG_SLOW_COEFF: slow_pole_r = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drive_sample(input logic [SAMPLE_BITS-1:0] smp, input bit typed,
                              input gain_result_t want);
    gain_result_t pred;
    int unsigned  gap;
    in_valid_i  <= 1'b1;
    sample_in_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = compress_sample(smp);
    pending_results.push_back(typed ? want : pred);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    gain_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: sample_out %0d gain %0d",
                               sample_out_o, gain_o));
      end else begin
        want = pending_results.pop_front();
        if (want.smp_out !== sample_out_o)
          note_failure($sformatf("sample_out expected %0d got %0d",
                                 want.smp_out, sample_out_o));
        if (want.gain !== gain_o)
          note_failure($sformatf("gain expected %0d got %0d", want.gain, gain_o));
      end
    end
  end

  // Receiver: random stall runs, one long hold-off on request.
  initial begin
    int unsigned r;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else if (calm_mode || r < 50) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else if (r < 92) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk_i);
      end
    end
  end

  initial begin
    gain_result_t          want;
    logic [COEFF_BITS-1:0] amt;
    logic [COEFF_BITS-1:0] fp;
    logic [COEFF_BITS-1:0] sp;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        write_reg(dir_tbl[i].idx, COEFF_BITS'(dir_tbl[i].value));
      end else begin
        want.smp_out = dir_tbl[i].exp_smp;
        want.gain    = dir_tbl[i].exp_gain;
        drive_sample(dir_tbl[i].value, dir_tbl[i].typed, want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          amt = '1;
          fp  = '0;
          sp  = '0;
        end
        1: begin
          amt = '1;
          fp  = '1;
          sp  = '1;
        end
        2: begin
          amt = '0;
          fp  = pick_reg_value();
          sp  = pick_reg_value();
        end
        default: begin
          amt = pick_reg_value();
          fp  = pick_reg_value();
          sp  = pick_reg_value();
        end
      endcase
      write_reg(CFG_AMOUNT, amt);
      write_reg(CFG_FAST_COEFF, fp);
      write_reg(CFG_SLOW_COEFF, sp);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_NONE, COEFF_BITS'($urandom));
      calm_mode = (ph == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 4 && n == 10) hold_off_req = 1'b1;
        if (ph == 5 && n == 25) begin
          in_valid_i <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk_i);
          @(posedge clk_i);
        end
        drive_sample(pick_sample(), 1'b0, want);
      end
      calm_mode = 1'b0;
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
